// File: hdl/i128div_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i128div_pkg
// Shared types and constants for the 128-bit signed/unsigned integer divider.
// ----------------------------------------------------------------------------
package i128div_pkg;

  // Operand geometry: ports always carry two 64-bit halves
  localparam int HALF_BITS         = 64;
  localparam int FULL_BITS         = 2 * HALF_BITS;
  localparam int OPERAND_BITS_DEF  = 128;

  // Division mode carried in the action field
  localparam logic ACT_UNSIGNED = 1'b0;
  localparam logic ACT_SIGNED   = 1'b1;

  // Input item
  typedef struct packed {
    logic                 action;
    logic [HALF_BITS-1:0] dividend_lo;
    logic [HALF_BITS-1:0] dividend_hi;
    logic [HALF_BITS-1:0] divisor_lo;
    logic [HALF_BITS-1:0] divisor_hi;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [HALF_BITS-1:0] quotient_lo;
    logic [HALF_BITS-1:0] quotient_hi;
    logic [HALF_BITS-1:0] remainder_lo;
    logic [HALF_BITS-1:0] remainder_hi;
    logic                 div_by_zero;
  } out_item_t;

endpackage

`default_nettype wire

// File: hdl/int128_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// From input transfer to result for a nonzero divisor the sequencer runs two
// operand sign fix-ups (S_NEG_N, S_NEG_D), one cycle per quotient bit in the
// shared subtractor (S_DIV), two result sign fix-ups (S_NEG_Q, S_NEG_R) and
// the output state S_DONE; a zero divisor goes straight from idle to S_DONE.
// The block holds one item at a time and takes a new one only in idle. Reset
// (rst_n low, synchronous) returns the sequencer to idle and drops out_valid.
// ----------------------------------------------------------------------------
// int128_divider
// Radix-2 restoring divider, unsigned or two's complement signed, producing
// quotient and remainder. One shared subtractor serves the division steps and
// the sign negations.
// ----------------------------------------------------------------------------
module int128_divider #(
  parameter int OPERAND_BITS = i128div_pkg::OPERAND_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  i128div_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output i128div_pkg::out_item_t out_data
);

  localparam int W     = OPERAND_BITS;
  localparam int CNT_W = $clog2(W);
  localparam int HB    = i128div_pkg::HALF_BITS;
  localparam int FB    = i128div_pkg::FULL_BITS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_NEG_N = 7'b0000010,
    S_NEG_D = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_NEG_Q = 7'b0010000,
    S_NEG_R = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [W-1:0]       num_r, num_nxt;   // dividend, then quotient
  logic [W-1:0]       den_r, den_nxt;
  logic [W-1:0]       rem_r, rem_nxt;
  logic               nneg_r, nneg_nxt;
  logic               dneg_r, dneg_nxt;
  logic               dz_r, dz_nxt;

  logic [FB-1:0]      n_in_full, d_in_full;
  logic [W-1:0]       n_in, d_in;
  logic [W+1:0]       sub_a, sub_b, sub_y;
  logic               borrow;
  logic [FB-1:0]      q_full, r_full;

  // Operands masked to the configured width
  assign n_in_full = {in_data.dividend_hi, in_data.dividend_lo};
  assign d_in_full = {in_data.divisor_hi, in_data.divisor_lo};
  assign n_in      = n_in_full[W-1:0];
  assign d_in      = d_in_full[W-1:0];

  // Shared subtractor: division step or two's complement negation
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state_r)
      S_DIV: begin
        sub_a = {1'b0, rem_r, num_r[W-1]};
        sub_b = {2'b00, den_r};
      end
      S_NEG_N: sub_b = {2'b00, num_r};
      S_NEG_D: sub_b = {2'b00, den_r};
      S_NEG_Q: sub_b = {2'b00, num_r};
      S_NEG_R: sub_b = {2'b00, rem_r};
      default: sub_b = '0;
    endcase
  end

  assign sub_y  = sub_a - sub_b;
  assign borrow = sub_y[W+1];

  // Sequencer and datapath next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    nneg_nxt  = nneg_r;
    dneg_nxt  = dneg_r;
    dz_nxt    = dz_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          nneg_nxt = (in_data.action == i128div_pkg::ACT_SIGNED) && n_in[W-1];
          dneg_nxt = (in_data.action == i128div_pkg::ACT_SIGNED) && d_in[W-1];
          dz_nxt   = (d_in == '0);
          den_nxt  = d_in;
          cnt_nxt  = CNT_W'(W - 1);
          if (d_in == '0) begin
            // zero divisor: all-ones quotient, remainder is the dividend
            num_nxt   = '1;
            rem_nxt   = n_in;
            state_nxt = S_DONE;
          end else begin
            num_nxt   = n_in;
            rem_nxt   = '0;
            state_nxt = S_NEG_N;
          end
        end
      end
      S_NEG_N: begin
        if (nneg_r) num_nxt = sub_y[W-1:0];
        state_nxt = S_NEG_D;
      end
      S_NEG_D: begin
        if (dneg_r) den_nxt = sub_y[W-1:0];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // shift the next dividend bit into the remainder, quotient bit in at the bottom
        if (!borrow) begin
          rem_nxt = sub_y[W-1:0];
        end else begin
          rem_nxt = {rem_r[W-2:0], num_r[W-1]};
        end
        num_nxt = {num_r[W-2:0], ~borrow};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_NEG_Q;
      end
      S_NEG_Q: begin
        if (nneg_r != dneg_r) num_nxt = sub_y[W-1:0];
        state_nxt = S_NEG_R;
      end
      S_NEG_R: begin
        if (nneg_r) rem_nxt = sub_y[W-1:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    nneg_r <= nneg_nxt;
    dneg_r <= dneg_nxt;
    dz_r   <= dz_nxt;
  end

  // Handshake and result fields, zero above the operand width
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign q_full    = FB'(num_r);
  assign r_full    = FB'(rem_r);

  always_comb begin
    out_data.quotient_lo  = q_full[HB-1:0];
    out_data.quotient_hi  = q_full[FB-1:HB];
    out_data.remainder_lo = r_full[HB-1:0];
    out_data.remainder_hi = r_full[FB-1:HB];
    out_data.div_by_zero  = dz_r;
  end

  // Assertions
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output sides open together");

  // a zero divisor skips the loop; any other divisor must iterate first
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (d_in != '0)) |=> !out_valid)
    else $error("result presented in the cycle after input transfer");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == '0) |=> (state_r == S_NEG_Q))
    else $error("division loop did not finish on the last bit");

  a_zero_quot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.div_by_zero) |-> (num_r == '1))
    else $error("zero divisor without all-ones quotient");

endmodule

`default_nettype wire
